>>> src/assert_macros.svh
// assertion macros shared by the interval set rtl
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASRT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASRT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASRT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ivs_pkg.sv
// shared types, codes and helpers for the interval set boolean block
// no dependencies
package ivs_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int TIME_WIDTH_DEF    = 32;
   localparam int MAX_RESULTS       = 32;
   localparam int RES_CNT_W         = 6;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] OP_AND    = 3'd0;
   localparam logic [2:0] OP_OR     = 3'd1;
   localparam logic [2:0] OP_XOR    = 3'd2;
   localparam logic [2:0] OP_ANDNOT = 3'd3;
   localparam logic [2:0] OP_NOT    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clr;
      logic vld;
      logic first;
      logic series;
   } bnd_ctl_type;

   function automatic logic op_eval(input logic [2:0] mode, input logic a, input logic b);
      logic r;
      unique case (mode)
         OP_AND:    r = a & b;
         OP_OR:     r = a | b;
         OP_XOR:    r = a ^ b;
         OP_ANDNOT: r = a & ~b;
         OP_NOT:    r = ~a;
         default:   r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> src/ivs_store.sv
// interval store memory: series a and b in separate halves, one write and one read port
// depends on ivs_pkg
module ivs_store import ivs_pkg::*; #(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_INTERVALS):0] wr_addr,
   input  logic [2*TIME_WIDTH-1:0]       wr_data,
   input  logic [$clog2(MAX_INTERVALS):0] rd_addr,
   output logic [2*TIME_WIDTH-1:0]       rd_data
);
   localparam int AW    = $clog2(MAX_INTERVALS) + 1;
   localparam int DEPTH = 2 ** AW;

   logic [2*TIME_WIDTH-1:0] mem_ff [DEPTH];
   logic [2*TIME_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ivs_bound.sv
// boundary unit: per stored interval finds the next boundary after t and coverage at t
// depends on ivs_pkg
module ivs_bound import ivs_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bnd_ctl_type                  ctl,
   input  logic signed [TIME_WIDTH:0]   t,
   input  logic [TIME_WIDTH-1:0]        ent_s,
   input  logic [TIME_WIDTH-1:0]        ent_e,
   output logic signed [TIME_WIDTH:0]   best,
   output logic                         found,
   output logic                         cov_a,
   output logic                         cov_b
);
   localparam int XW = TIME_WIDTH + 1;

   logic signed [XW-1:0] s_x, e_x, e_inc, cand;
   logic                 gt, ge, cand_ok, take, covered;

   logic signed [XW-1:0] best_ff, best_in;
   logic                 found_ff, found_in, cov_a_ff, cov_a_in, cov_b_ff, cov_b_in;

   assign s_x   = XW'(signed'(ent_s));
   assign e_x   = XW'(signed'(ent_e));
   assign e_inc = e_x + XW'(1);

   // first pass has no lower bound: the smallest start is the first boundary
   assign gt      = ctl.first | (s_x > t);
   assign ge      = ~ctl.first & (e_x >= t);
   assign cand    = gt ? s_x : e_inc;
   assign cand_ok = gt | ge;
   assign take    = cand_ok & (~found_ff | (cand < best_ff));
   assign covered = ~gt & ge;

   always_comb begin
      best_in  = best_ff;
      found_in = found_ff;
      cov_a_in = cov_a_ff;
      cov_b_in = cov_b_ff;
      if (ctl.clr) begin
         found_in = 1'b0;
         cov_a_in = 1'b0;
         cov_b_in = 1'b0;
      end else if (ctl.vld) begin
         if (take) begin
            best_in  = cand;
            found_in = 1'b1;
         end
         if (covered && !ctl.series) cov_a_in = 1'b1;
         if (covered && ctl.series)  cov_b_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      if (reset) begin
         found_ff <= 1'b0;
         cov_a_ff <= 1'b0;
         cov_b_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         cov_a_ff <= cov_a_in;
         cov_b_ff <= cov_b_in;
      end
   end

   assign best  = best_ff;
   assign found = found_ff;
   assign cov_a = cov_a_ff;
   assign cov_b = cov_b_ff;

endmodule

>>> src/interval_set_boolean.sv
// Boolean operations on two sets of closed integer intervals. Loads and clears are handled
// in the idle state, so they can be sent back to back. A run walks the boundaries of the result
// in time order: each step is one pass of the shared boundary unit over every stored
// interval (A then B, only A in not mode) read from the store memory, followed by the evaluate
// state, and there are at most 2 * (Na + Nb) + 1 steps; the final item is handed out once the
// result side is free. Modes above not go straight to the final item. The block takes no new
// item while a run is in progress. Results leave through a registered output stage.
// depends on ivs_pkg, ivs_store, ivs_bound and assert_macros.svh
`include "assert_macros.svh"
module interval_set_boolean import ivs_pkg::*; #(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic               req_series_select,
   input  logic signed [31:0] req_start_time,
   input  logic signed [31:0] req_end_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_start,
   output logic signed [31:0] rsp_result_end,
   output logic               rsp_last_flag,
   output logic               rsp_empty_flag,
   output logic               rsp_overflow_flag,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_wr_data
);
   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int AW = IW + 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int TW = TIME_WIDTH;
   localparam int XW = TW + 1;

   state_type state_ff, state_in;
   logic [2:0]    op_mode_ff;
   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic          dropped_ff, dropped_in;
   logic          scan_sel_ff, scan_sel_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          issuing_ff, issuing_in;
   logic          rd_vld_ff, rd_vld_in, rd_sel_ff, rd_sel_in;
   logic signed [XW-1:0] t_ff, t_in;
   logic          first_ff, first_in, prev_ff, prev_in;
   logic [TW-1:0] open_ff, open_in, pend_s_ff, pend_s_in, pend_e_ff, pend_e_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic          rsp_empty_ff, rsp_empty_in, rsp_ovf_ff, rsp_ovf_in;
   logic [TW-1:0] rsp_s_ff, rsp_s_in, rsp_e_ff, rsp_e_in;

   logic          req_xfer, ld_ok, wr_en, scan_b, in_rng, out_free, cur, close;
   logic [TW-1:0] ld_s, ld_e;
   logic [CW-1:0] ld_cnt;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [2*TW-1:0] rd_data;
   bnd_ctl_type   bnd_ctl;
   logic signed [XW-1:0] best;
   logic          found, cov_a, cov_b, scan_go;

   assign req_xfer = req_valid & req_ready;
   assign ld_s     = TW'($unsigned(req_start_time));
   assign ld_e     = TW'($unsigned(req_end_time));
   assign ld_cnt   = req_series_select ? cnt_b_ff : cnt_a_ff;
   assign ld_ok    = (signed'(ld_s) <= signed'(ld_e)) & (ld_cnt < CW'(MAX_INTERVALS));
   assign wr_en    = req_xfer & (req_command == CMD_LOAD) & ld_ok;
   assign wr_addr  = {req_series_select, ld_cnt[IW-1:0]};
   assign rd_addr  = {scan_sel_ff, scan_idx_ff[IW-1:0]};

   ivs_store #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_WIDTH(TIME_WIDTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({ld_s, ld_e}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign bnd_ctl.clr    = scan_go;
   assign bnd_ctl.vld    = rd_vld_ff;
   assign bnd_ctl.first  = first_ff;
   assign bnd_ctl.series = rd_sel_ff;

   ivs_bound #(.TIME_WIDTH(TIME_WIDTH)) u_bound (
      .clock (clock),
      .reset (reset),
      .ctl   (bnd_ctl),
      .t     (t_ff),
      .ent_s (rd_data[2*TW-1:TW]),
      .ent_e (rd_data[TW-1:0]),
      .best  (best),
      .found (found),
      .cov_a (cov_a),
      .cov_b (cov_b)
   );

   assign scan_b   = (op_mode_ff != OP_NOT);
   assign in_rng   = scan_sel_ff ? (scan_b & (scan_idx_ff < cnt_b_ff)) : (scan_idx_ff < cnt_a_ff);
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign cur      = op_eval(op_mode_ff, cov_a, cov_b);
   assign close    = ~cur & prev_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      dropped_in   = dropped_ff;
      scan_sel_in  = scan_sel_ff;
      scan_idx_in  = scan_idx_ff;
      issuing_in   = issuing_ff;
      rd_vld_in    = 1'b0;
      rd_sel_in    = rd_sel_ff;
      t_in         = t_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      open_in      = open_ff;
      pend_vld_in  = pend_vld_ff;
      pend_s_in    = pend_s_ff;
      pend_e_in    = pend_e_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_s_in     = rsp_s_ff;
      rsp_e_in     = rsp_e_ff;
      scan_go      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               priority case (req_command)
                  CMD_LOAD: begin
                     if (!ld_ok) dropped_in = 1'b1;
                     else if (req_series_select) cnt_b_in = cnt_b_ff + CW'(1);
                     else cnt_a_in = cnt_a_ff + CW'(1);
                  end
                  CMD_CLEAR: begin
                     cnt_a_in   = '0;
                     cnt_b_in   = '0;
                     dropped_in = 1'b0;
                  end
                  CMD_RUN: begin
                     first_in    = 1'b1;
                     prev_in     = 1'b0;
                     pend_vld_in = 1'b0;
                     res_cnt_in  = '0;
                     if (op_mode_ff > OP_NOT) state_in = ST_FINISH;
                     else scan_go = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               if (in_rng) begin
                  rd_vld_in   = 1'b1;
                  rd_sel_in   = scan_sel_ff;
                  scan_idx_in = scan_idx_ff + CW'(1);
               end else if (!scan_sel_ff && scan_b) begin
                  scan_sel_in = 1'b1;
                  scan_idx_in = '0;
               end else begin
                  issuing_in = 1'b0;
               end
            end else if (!rd_vld_ff) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (first_ff) begin
               if (!found) state_in = ST_FINISH;
               else begin
                  t_in     = best;
                  first_in = 1'b0;
                  scan_go  = 1'b1;
               end
            end else if (!(close && pend_vld_ff && !out_free)) begin
               if (close) begin
                  // earlier result goes out now, it is known not to be the last
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_s_in     = pend_s_ff;
                     rsp_e_in     = pend_e_ff;
                     rsp_last_in  = 1'b0;
                     rsp_empty_in = 1'b0;
                     rsp_ovf_in   = dropped_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_s_in   = open_ff;
                  pend_e_in   = TW'(t_ff - XW'(1));
                  res_cnt_in  = res_cnt_ff + RES_CNT_W'(1);
               end
               if (cur && !prev_ff) open_in = TW'(t_ff);
               prev_in = cur;
               if (close && (res_cnt_ff == RES_CNT_W'(MAX_RESULTS - 1))) state_in = ST_FINISH;
               else if (found) begin
                  t_in    = best;
                  scan_go = 1'b1;
               end else state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_empty_in = ~pend_vld_ff;
               rsp_ovf_in   = dropped_ff;
               rsp_s_in     = pend_vld_ff ? pend_s_ff : '0;
               rsp_e_in     = pend_vld_ff ? pend_e_ff : '0;
               pend_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (scan_go) begin
         state_in    = ST_SCAN;
         scan_sel_in = 1'b0;
         scan_idx_in = '0;
         issuing_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      open_ff   <= open_in;
      pend_s_ff <= pend_s_in;
      pend_e_ff <= pend_e_in;
      rsp_s_ff  <= rsp_s_in;
      rsp_e_ff  <= rsp_e_in;
      rd_sel_ff <= rd_sel_in;
      scan_sel_ff <= scan_sel_in;
      scan_idx_ff <= scan_idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_mode_ff   <= OP_AND;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         issuing_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         first_ff     <= 1'b0;
         prev_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         rsp_empty_ff <= 1'b0;
         rsp_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) op_mode_ff <= csr_wr_data;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         dropped_ff   <= dropped_in;
         issuing_ff   <= issuing_in;
         rd_vld_ff    <= rd_vld_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         pend_vld_ff  <= pend_vld_in;
         res_cnt_ff   <= res_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_start  = signed'(32'(rsp_s_ff));
   assign rsp_result_end    = signed'(32'(rsp_e_ff));
   assign rsp_last_flag     = rsp_last_ff;
   assign rsp_empty_flag    = rsp_empty_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;

   `ASRT_ALWAYS(a_cnt_bound, (cnt_a_ff <= CW'(MAX_INTERVALS)) && (cnt_b_ff <= CW'(MAX_INTERVALS)), "store count past capacity")
   `ASRT_ALWAYS(a_res_bound, res_cnt_ff <= RES_CNT_W'(MAX_RESULTS), "result count past limit")
   `ASRT_IMPLY(a_empty_item, rsp_valid_ff && rsp_empty_ff, rsp_last_ff && (rsp_s_ff == '0) && (rsp_e_ff == '0), "empty item malformed")
   `ASRT_IMPLY(a_pend_idle, state_ff == ST_IDLE, !pend_vld_ff, "pending result left after run")
   `ASRT_NEXT(a_scan_read, (state_ff == ST_SCAN) && issuing_ff && in_rng, rd_vld_ff, "scan read lost")

endmodule

>>> tb/sv/interval_set_boolean_test.sv
// self-checking testbench for interval_set_boolean: loads, clears and runs in every mode
// depends on ivs_pkg and the interval_set_boolean rtl
`timescale 1ns / 100ps

class interval_scoreboard;
   typedef struct {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic last;
      logic empty;
      logic ovf;
   } span_item;

   logic signed [63:0] a_lo[16], a_hi[16], b_lo[16], b_hi[16];
   int na, nb;
   bit dropped;
   logic [2:0] mode;
   span_item pending[$];
   int errors;
   logic signed [63:0] out_lo[$], out_hi[$];

   function new();
      na = 0; nb = 0; dropped = 0; mode = ivs_pkg::OP_AND; errors = 0;
   endfunction

   function void merge(input logic signed [63:0] slo[16], input logic signed [63:0] shi[16],
                       input int n, output logic signed [63:0] mlo[16],
                       output logic signed [63:0] mhi[16], output int m);
      logic signed [63:0] lo[16], hi[16], x, y;
      int j;
      m = 0;
      for (int i = 0; i < n; i++) begin
         x = slo[i]; y = shi[i]; j = i;
         while (j > 0 && lo[j-1] > x) begin
            lo[j] = lo[j-1]; hi[j] = hi[j-1]; j--;
         end
         lo[j] = x; hi[j] = y;
      end
      for (int i = 0; i < n; i++) begin
         if (m > 0 && lo[i] <= mhi[m-1] + 1) begin
            if (hi[i] > mhi[m-1]) mhi[m-1] = hi[i];
         end else begin
            mlo[m] = lo[i]; mhi[m] = hi[i]; m++;
         end
      end
   endfunction

   function bit op_holds(bit a, bit b);
      case (mode)
         ivs_pkg::OP_AND:    return a && b;
         ivs_pkg::OP_OR:     return a || b;
         ivs_pkg::OP_XOR:    return a != b;
         ivs_pkg::OP_ANDNOT: return a && !b;
         default:            return 0;
      endcase
   endfunction

   function void emit(logic signed [63:0] lo, logic signed [63:0] hi);
      if (out_lo.size() < 32) begin
         out_lo.insert(out_lo.size(), lo); out_hi.insert(out_hi.size(), hi);
      end
   endfunction

   function void run_sweep();
      logic signed [63:0] ml[16], mh[16], bl[16], bh[16];
      logic signed [63:0] et[$], t, open_at;
      int ea[$], eb[$];
      int ma, mb, ca, cb, i;
      bit prev, cur;
      out_lo.delete(); out_hi.delete();
      merge(a_lo, a_hi, na, ml, mh, ma);
      if (mode == ivs_pkg::OP_NOT) begin
         for (int k = 1; k < ma; k++)
            if (ml[k] > mh[k-1] + 1) emit(mh[k-1] + 1, ml[k] - 1);
         return;
      end
      if (mode > ivs_pkg::OP_NOT) return;
      merge(b_lo, b_hi, nb, bl, bh, mb);
      // order of events at equal times does not matter, counts are summed per time
      for (int k = 0; k < ma; k++) begin
         et.insert(et.size(), ml[k]); ea.insert(ea.size(), 1); eb.insert(eb.size(), 0);
         et.insert(et.size(), mh[k] + 1); ea.insert(ea.size(), -1); eb.insert(eb.size(), 0);
      end
      for (int k = 0; k < mb; k++) begin
         et.insert(et.size(), bl[k]); ea.insert(ea.size(), 0); eb.insert(eb.size(), 1);
         et.insert(et.size(), bh[k] + 1); ea.insert(ea.size(), 0); eb.insert(eb.size(), -1);
      end
      for (int p = 1; p < et.size(); p++)
         for (int q = p; q > 0 && et[q-1] > et[q]; q--) begin
            t = et[q]; et[q] = et[q-1]; et[q-1] = t;
            ca = ea[q]; ea[q] = ea[q-1]; ea[q-1] = ca;
            cb = eb[q]; eb[q] = eb[q-1]; eb[q-1] = cb;
         end
      ca = 0; cb = 0; prev = 0; open_at = 0; i = 0;
      while (i < et.size()) begin
         t = et[i];
         while (i < et.size() && et[i] == t) begin
            ca += ea[i]; cb += eb[i]; i++;
         end
         cur = op_holds(ca > 0, cb > 0);
         if (cur && !prev) open_at = t;
         else if (!cur && prev) emit(open_at, t - 1);
         prev = cur;
      end
   endfunction

   function void note_request(logic [1:0] cmd, logic sel, logic signed [31:0] s,
                              logic signed [31:0] e);
      span_item it;
      if (cmd == ivs_pkg::CMD_LOAD) begin
         if (s > e || (sel ? nb : na) >= 16) dropped = 1;
         else if (sel) begin
            b_lo[nb] = s; b_hi[nb] = e; nb++;
         end else begin
            a_lo[na] = s; a_hi[na] = e; na++;
         end
      end else if (cmd == ivs_pkg::CMD_CLEAR) begin
         na = 0; nb = 0; dropped = 0;
      end else if (cmd == ivs_pkg::CMD_RUN) begin
         run_sweep();
         if (out_lo.size() == 0) begin
            it.lo = 0; it.hi = 0; it.last = 1; it.empty = 1; it.ovf = dropped;
            pending.insert(pending.size(), it);
         end else
            for (int k = 0; k < out_lo.size(); k++) begin
               it.lo = out_lo[k][31:0]; it.hi = out_hi[k][31:0];
               it.last = (k + 1 == out_lo.size()); it.empty = 0; it.ovf = dropped;
               pending.insert(pending.size(), it);
            end
      end
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   task check_result(logic signed [31:0] lo, logic signed [31:0] hi, logic last,
                     logic empty, logic ovf);
      span_item x;
      if (pending.size() == 0) begin
         report($sformatf("unexpected transfer [%0d,%0d]", lo, hi));
         return;
      end
      x = pending.pop_front();
      if (lo !== x.lo || hi !== x.hi || last !== x.last || empty !== x.empty
          || ovf !== x.ovf)
         report($sformatf("got [%0d,%0d] l%b e%b o%b, want [%0d,%0d] l%b e%b o%b",
                lo, hi, last, empty, ovf, x.lo, x.hi, x.last, x.empty, x.ovf));
   endtask
endclass

module interval_set_boolean_test;
   import ivs_pkg::*;

   // command code with no meaning, must be ignored
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_wr_en = 0;
   logic req_ready, rsp_valid;
   logic [1:0] req_command = CMD_LOAD;
   logic req_series_select = 0;
   logic signed [31:0] req_start_time = 0, req_end_time = 0;
   logic signed [31:0] rsp_result_start, rsp_result_end;
   logic rsp_last_flag, rsp_empty_flag, rsp_overflow_flag;
   logic [2:0] csr_wr_data = OP_AND;
   bit stim_done = 0;
   int stall_left = 0;
   interval_scoreboard board = new();

   interval_set_boolean i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_series_select,
      .req_start_time, .req_end_time, .rsp_valid, .rsp_ready, .rsp_result_start,
      .rsp_result_end, .rsp_last_flag, .rsp_empty_flag, .rsp_overflow_flag,
      .csr_wr_en, .csr_wr_data
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // starts right after an accepting edge or from idle; valid drops only across a gap
   task send(logic [1:0] cmd, logic sel, logic signed [31:0] s, logic signed [31:0] e);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_command <= cmd; req_series_select <= sel;
      req_start_time <= s; req_end_time <= e; req_valid <= 1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      board.note_request(cmd, sel, s, e);
   endtask

   task drain();
      @(negedge clock);
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task set_mode(logic [2:0] m);
      drain();
      csr_wr_data <= m; csr_wr_en <= 1;
      @(negedge clock);
      csr_wr_en <= 0;
      board.mode = m;
   endtask

   function logic signed [31:0] rand_time(int span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, span)) - span / 2;
   endfunction

   // result side stalls, mostly short with an occasional long one
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_ready <= 0;
         stall_left <= gap_len();
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_result_start, rsp_result_end, rsp_last_flag,
                            rsp_empty_flag, rsp_overflow_flag);

   initial begin
      logic signed [31:0] s, e;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: extremes, empty runs, adjacency, dropped load, unused codes
      send(CMD_RUN, 0, 0, 0);
      send(CMD_LOAD, 0, 32'sh8000_0000, -10);
      send(CMD_LOAD, 0, -9, 5);
      send(CMD_LOAD, 0, 20, 32'sh7fff_fffe);
      send(CMD_LOAD, 1, 0, 30);
      send(CMD_LOAD, 1, 32'sh7fff_fffe, 32'sh7fff_fffe);
      send(CMD_LOAD, 1, 5, 4);
      send(CMD_RUN, 0, 0, 0);
      send(CMD_UNUSED, 1, -1, -1);
      for (int m = 1; m < 8; m++) begin
         set_mode(m[2:0]);
         send(CMD_RUN, 0, 0, 0);
      end
      send(CMD_CLEAR, 0, 0, 0);
      set_mode(OP_XOR);
      for (int k = 0; k < 17; k++) send(CMD_LOAD, k[0], k * 4, k * 4 + k[1]);
      send(CMD_RUN, 0, 0, 0);
      // random phases of loads, some malformed or replaced by unused codes, followed by runs
      for (int ph = 0; ph < 10; ph++) begin
         set_mode(3'($urandom_range(0, 5)));
         send(CMD_CLEAR, 0, 0, 0);
         repeat ($urandom_range(2, 12)) begin
            s = rand_time(200);
            e = ($urandom_range(0, 7) == 0) ? s - 1 : s + $urandom_range(0, 30);
            if (s > 32'sh7fff_ffe0) e = s;
            send($urandom_range(0, 15) == 0 ? CMD_UNUSED : CMD_LOAD,
                 1'($urandom_range(0, 1)), s, e);
         end
         send(CMD_RUN, 0, 0, 0);
         if ($urandom_range(0, 1)) send(CMD_RUN, 0, 0, 0);
      end
      drain();
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("interval_set_boolean_test: PASS");
      else
         $display("interval_set_boolean_test: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("interval_set_boolean_test: FAIL");
      $finish;
   end
endmodule
